// File: rtl/core/isms_pkg.sv
// Shared opcodes, status codes and controller/datapath interface types.
`default_nettype none
package isms_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_REM   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNCH  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_INVAL = 2'd3;

  // Width of the read index field.
  localparam int IDX_W = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture request, reset scan counters
    logic       rd_issue;   // read the active bank
    logic       rd_use_idx; // address from the request index, not the scan counter
    logic       p1_eval;    // first add pass: merge or count survivor
    logic       rescan;     // restart the scan counter
    logic       i_inc;      // next stored entry
    logic       ins_write;  // write the merged interval
    logic       ent_write;  // copy the current entry
    logic       part_lo;    // write the part below the removed span
    logic       part_hi;    // write the part above the removed span
    logic       mark_chg;   // a removal hit an entry
    logic       commit;     // swap banks, take new count
    logic       clear;      // empty the set
    logic       resp;       // emit a result
    logic [1:0] resp_code;
    logic       resp_data;  // result carries the read entry
  } isms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       inv;        // lo > hi
    logic       idx_ok;
    logic       scan_done;
    logic       contained;  // entry contains the request
    logic       overlap;    // entry touches or overlaps the request
    logic       below;      // entry starts below the request
    logic       above;      // entry ends above the request
    logic       before_new; // entry sorts before the merged interval
    logic       inserted;
    logic       full_add;
    logic       w_full;
    logic       changed;
  } isms_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/isms_ctrl.sv
// Controller state machine sequencing the scan passes over the interval table.
`default_nettype none
module isms_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire isms_pkg::isms_stat_t st,
  output isms_pkg::isms_cmd_t     cmd
);
  import isms_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_RDW    = 4'd2;
  localparam logic [3:0] S_P1_RD  = 4'd3;
  localparam logic [3:0] S_P1_EV  = 4'd4;
  localparam logic [3:0] S_P1_END = 4'd5;
  localparam logic [3:0] S_P2_RD  = 4'd6;
  localparam logic [3:0] S_P2_EV  = 4'd7;
  localparam logic [3:0] S_R_RD   = 4'd8;
  localparam logic [3:0] S_R_EV   = 4'd9;
  localparam logic [3:0] S_R_SPL  = 4'd10;
  localparam logic [3:0] S_R_END  = 4'd11;
  localparam logic [3:0] S_COMMIT = 4'd12;
  localparam logic [3:0] S_CLR    = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.op)
          OP_ADD, OP_REM: begin
            if (st.inv) begin
              cmd.resp      = 1'b1;
              cmd.resp_code = ST_INVAL;
              state_nxt     = S_IDLE;
            end else if (st.op == OP_ADD) begin
              state_nxt = S_P1_RD;
            end else begin
              state_nxt = S_R_RD;
            end
          end
          OP_READ: begin
            if (st.idx_ok) begin
              cmd.rd_issue   = 1'b1;
              cmd.rd_use_idx = 1'b1;
              state_nxt      = S_RDW;
            end else begin
              cmd.resp      = 1'b1;
              cmd.resp_code = ST_INVAL;
              state_nxt     = S_IDLE;
            end
          end
          default: state_nxt = S_CLR;
        endcase
      end
      S_RDW: begin
        cmd.resp      = 1'b1;
        cmd.resp_code = ST_OK;
        cmd.resp_data = 1'b1;
        state_nxt     = S_IDLE;
      end
      // First add pass: look for containment and gather the merged span.
      S_P1_RD: begin
        if (st.scan_done) begin
          state_nxt = S_P1_END;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_P1_EV;
        end
      end
      S_P1_EV: begin
        if (st.contained) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = ST_UNCH;
          state_nxt     = S_IDLE;
        end else begin
          cmd.p1_eval = 1'b1;
          cmd.i_inc   = 1'b1;
          state_nxt   = S_P1_RD;
        end
      end
      S_P1_END: begin
        if (st.full_add) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = ST_FULL;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rescan = 1'b1;
          state_nxt  = S_P2_RD;
        end
      end
      // Second add pass: copy survivors, insert the merged span in order.
      S_P2_RD: begin
        if (st.scan_done) begin
          cmd.ins_write = !st.inserted;
          state_nxt     = S_COMMIT;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_P2_EV;
        end
      end
      S_P2_EV: begin
        if (st.overlap) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_P2_RD;
        end else if (!st.inserted && !st.before_new) begin
          cmd.ins_write = 1'b1;
        end else begin
          cmd.ent_write = 1'b1;
          cmd.i_inc     = 1'b1;
          state_nxt     = S_P2_RD;
        end
      end
      // Remove pass: copy, trim or split each entry into the spare bank, or drop it.
      S_R_RD: begin
        if (st.scan_done) begin
          state_nxt = S_R_END;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_R_EV;
        end
      end
      S_R_EV: begin
        if (st.overlap) begin
          cmd.mark_chg = 1'b1;
          if (st.below) begin
            if (st.w_full) begin
              cmd.resp      = 1'b1;
              cmd.resp_code = ST_FULL;
              state_nxt     = S_IDLE;
            end else begin
              cmd.part_lo = 1'b1;
              if (st.above) begin
                state_nxt = S_R_SPL;
              end else begin
                cmd.i_inc = 1'b1;
                state_nxt = S_R_RD;
              end
            end
          end else if (st.above) begin
            if (st.w_full) begin
              cmd.resp      = 1'b1;
              cmd.resp_code = ST_FULL;
              state_nxt     = S_IDLE;
            end else begin
              cmd.part_hi = 1'b1;
              cmd.i_inc   = 1'b1;
              state_nxt   = S_R_RD;
            end
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = S_R_RD;
          end
        end else if (st.w_full) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = ST_FULL;
          state_nxt     = S_IDLE;
        end else begin
          cmd.ent_write = 1'b1;
          cmd.i_inc     = 1'b1;
          state_nxt     = S_R_RD;
        end
      end
      S_R_SPL: begin
        if (st.w_full) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = ST_FULL;
          state_nxt     = S_IDLE;
        end else begin
          cmd.part_hi = 1'b1;
          cmd.i_inc   = 1'b1;
          state_nxt   = S_R_RD;
        end
      end
      S_R_END: begin
        if (!st.changed) begin
          cmd.resp      = 1'b1;
          cmd.resp_code = ST_UNCH;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.resp      = 1'b1;
        cmd.resp_code = ST_OK;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/isms_dp.sv
// Datapath: two interval banks, scan counters, comparators and result register.
`default_nettype none
module isms_dp #(
  parameter int MAX_RANGES  = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = $clog2(MAX_RANGES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    in_op,
  input  wire logic signed [VALUE_WIDTH-1:0] in_range_lo,
  input  wire logic signed [VALUE_WIDTH-1:0] in_range_hi,
  input  wire logic [isms_pkg::IDX_W-1:0]    in_entry_index,
  input  wire isms_pkg::isms_cmd_t           cmd,
  output isms_pkg::isms_stat_t               st,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [CW-1:0]                      out_range_count,
  output logic signed [VALUE_WIDTH-1:0]      out_entry_lo,
  output logic signed [VALUE_WIDTH-1:0]      out_entry_hi
);
  import isms_pkg::*;

  localparam int AW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  // Two banks: one holds the set, the other receives the rewritten set.
  logic signed [VALUE_WIDTH-1:0] lo0_mem [MAX_RANGES];
  logic signed [VALUE_WIDTH-1:0] hi0_mem [MAX_RANGES];
  logic signed [VALUE_WIDTH-1:0] lo1_mem [MAX_RANGES];
  logic signed [VALUE_WIDTH-1:0] hi1_mem [MAX_RANGES];

  logic                          bank_r;
  logic [CW-1:0]                 count_r;
  logic [1:0]                    op_r;
  logic signed [VALUE_WIDTH-1:0] lo_r, hi_r, nlo_r, nhi_r, rlo_r, rhi_r;
  logic [IDX_W-1:0]              idx_r;
  logic [CW-1:0]                 i_r, w_r, n_r;
  logic                          inserted_r, changed_r;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic                          wr_en;
  logic signed [VALUE_WIDTH-1:0] wlo, whi;

  assign rd_addr = cmd.rd_use_idx ? AW'(idx_r) : AW'(i_r);
  assign wr_addr = AW'(w_r);
  assign wr_en   = cmd.ins_write | cmd.ent_write | cmd.part_lo | cmd.part_hi;

  // Write data selection.
  always_comb begin
    wlo = rlo_r;
    whi = rhi_r;
    if (cmd.ins_write) begin
      wlo = nlo_r;
      whi = nhi_r;
    end else if (cmd.part_lo) begin
      whi = lo_r;
    end else if (cmd.part_hi) begin
      wlo = hi_r;
    end
  end

  // Bank memories: write to the spare bank, registered read from the active one.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (bank_r) begin
        lo0_mem[wr_addr] <= wlo;
        hi0_mem[wr_addr] <= whi;
      end else begin
        lo1_mem[wr_addr] <= wlo;
        hi1_mem[wr_addr] <= whi;
      end
    end
    if (cmd.rd_issue) begin
      rlo_r <= bank_r ? lo1_mem[rd_addr] : lo0_mem[rd_addr];
      rhi_r <= bank_r ? hi1_mem[rd_addr] : hi0_mem[rd_addr];
    end
  end

  // Request capture and merged span.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      lo_r  <= in_range_lo;
      hi_r  <= in_range_hi;
      idx_r <= in_entry_index;
      nlo_r <= in_range_lo;
      nhi_r <= in_range_hi;
    end else if (cmd.p1_eval && st.overlap) begin
      if (rlo_r < nlo_r) nlo_r <= rlo_r;
      if (rhi_r > nhi_r) nhi_r <= rhi_r;
    end
  end

  // Control state: bank select, count, scan counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= 1'b0;
      count_r    <= '0;
      i_r        <= '0;
      w_r        <= '0;
      n_r        <= '0;
      inserted_r <= 1'b0;
      changed_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        i_r        <= '0;
        w_r        <= '0;
        n_r        <= '0;
        inserted_r <= 1'b0;
        changed_r  <= 1'b0;
      end else begin
        if (cmd.rescan) begin
          i_r <= '0;
        end else if (cmd.i_inc) begin
          i_r <= i_r + CW'(1);
        end
        if (wr_en) w_r <= w_r + CW'(1);
        if (cmd.p1_eval && !st.overlap) n_r <= n_r + CW'(1);
        if (cmd.ins_write) inserted_r <= 1'b1;
        if (cmd.mark_chg) changed_r <= 1'b1;
      end
      if (cmd.commit) begin
        bank_r  <= ~bank_r;
        count_r <= w_r;
      end else if (cmd.clear) begin
        count_r <= '0;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    st.op         = op_r;
    st.inv        = lo_r > hi_r;
    st.idx_ok     = CMPW'(idx_r) < CMPW'(count_r);
    st.scan_done  = (i_r == count_r);
    st.contained  = (rlo_r <= lo_r) && (hi_r <= rhi_r);
    st.overlap    = (rlo_r <= hi_r) && (lo_r <= rhi_r);
    st.below      = rlo_r < lo_r;
    st.above      = rhi_r > hi_r;
    st.before_new = (rlo_r < nlo_r) || ((rlo_r == nlo_r) && (rhi_r < nhi_r));
    st.inserted   = inserted_r;
    st.full_add   = (n_r == CW'(MAX_RANGES));
    st.w_full     = (w_r == CW'(MAX_RANGES));
    st.changed    = changed_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.resp;
    end
    if (cmd.resp) begin
      out_status      <= cmd.resp_code;
      out_range_count <= count_r;
      out_entry_lo    <= cmd.resp_data ? rlo_r : '0;
      out_entry_hi    <= cmd.resp_data ? rhi_r : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/interval_set_merge_split_core.sv
// Top level of the sorted interval set with add, remove, read and clear.
// A rejected request is answered from dispatch, a read after its read wait state, a clear
// after the clear state; remove scans once with a split state per split; add scans twice.
// One request at a time; busy stays high until the result strobe, whose cycle
// may already accept the next request. The scan passes over the table set the rate.
// Synchronous active-low reset empties the set; stored endpoints are not cleared.
`default_nettype none
module interval_set_merge_split_core #(
  parameter int MAX_RANGES  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_op,
  input  wire logic signed [VALUE_WIDTH-1:0]       in_range_lo,
  input  wire logic signed [VALUE_WIDTH-1:0]       in_range_hi,
  input  wire logic [isms_pkg::IDX_W-1:0]          in_entry_index,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic [$clog2(MAX_RANGES+1)-1:0]          out_range_count,
  output logic signed [VALUE_WIDTH-1:0]            out_entry_lo,
  output logic signed [VALUE_WIDTH-1:0]            out_entry_hi
);
  import isms_pkg::*;

  isms_cmd_t  cmd;
  isms_stat_t st;

  // Sequencer.
  isms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // Storage and compare logic.
  isms_dp #(
    .MAX_RANGES  (MAX_RANGES),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          ($clog2(MAX_RANGES + 1))
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_range_lo     (in_range_lo),
    .in_range_hi     (in_range_hi),
    .in_entry_index  (in_entry_index),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_range_count (out_range_count),
    .out_entry_lo    (out_entry_lo),
    .out_entry_hi    (out_entry_hi)
  );

endmodule
`default_nettype wire

// File: rtl/core/isms_checker.sv
// Port-level checks for the interval set core and their bind.
`default_nettype none
module isms_checker #(
  parameter int MAX_RANGES  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                out_valid,
  input wire logic [1:0]                          out_status,
  input wire logic [$clog2(MAX_RANGES+1)-1:0]     out_range_count,
  input wire logic signed [VALUE_WIDTH-1:0]       out_entry_lo,
  input wire logic signed [VALUE_WIDTH-1:0]       out_entry_hi
);
  import isms_pkg::*;

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // A result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A result is given only for a request that was in flight.
  a_result_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without request in flight");

  // The count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_range_count) <= MAX_RANGES))
    else $error("interval count out of range");

  // Only a successful read returns endpoints; this checks that non-OK results carry zero.
  a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_entry_lo == '0 && out_entry_hi == '0))
    else $error("endpoints nonzero on failed request");

endmodule

bind interval_set_merge_split_core isms_checker #(
  .MAX_RANGES  (MAX_RANGES),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_isms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_range_count (out_range_count),
  .out_entry_lo    (out_entry_lo),
  .out_entry_hi    (out_entry_hi)
);
`default_nettype wire
